// ===== rtl/core/rmq_pkg.sv =====
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and width helpers for the rotation matrix to
// quaternion pipeline.
// ---------------------------------------------------------------------------
package rmq_pkg;

    // Default binary point position of every matrix entry and component
    localparam int FRAC_BITS_DEF = 14;

    // Field widths
    localparam int M_W = 16;   // matrix entry
    localparam int N_W = 17;   // sum or difference of two entries
    localparam int Q_W = 16;   // quaternion component

    // Which output component takes the halved root; the other three are quotients
    typedef enum logic [1:0] {
        LEAD_W,
        LEAD_X,
        LEAD_Y,
        LEAD_Z
    } t_lead;

    // Numerators and routing that ride along with the square root
    typedef struct packed {
        logic signed [N_W-1:0] num_a;
        logic signed [N_W-1:0] num_b;
        logic signed [N_W-1:0] num_c;
        t_lead                 lead;
    } t_side;

    // Width of the clamped radicand before the binary point shift
    function automatic int rad_width(input int frac_bits);
        return (frac_bits >= 17) ? frac_bits + 1 : 18;
    endfunction

endpackage

// ===== rtl/core/rmq_front.sv =====
// ---------------------------------------------------------------------------
// rmq_front
// Trace test, leading axis pick, radicand and the three numerators.
// One register stage.
// ---------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m00,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m01,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m02,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m10,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m11,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m12,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m20,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m21,
    input  logic signed [rmq_pkg::M_W-1:0]              i_m22,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic [rmq_pkg::rad_width(FRAC_BITS)-1:0]    o_rad,
    output rmq_pkg::t_side                              o_side
);
    import rmq_pkg::*;

    localparam int RAD_W = rad_width(FRAC_BITS);
    localparam int SW    = RAD_W + 2;
    localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC_BITS;

    logic                    r_v;
    logic [RAD_W-1:0]        r_rad;
    t_side                   r_side;
    logic [RAD_W-1:0]        n_rad;
    t_side                   n_side;
    logic                    w_hold;
    logic signed [SW-1:0]    w_d0, w_d1, w_d2, w_trace, w_dmax, w_rad;
    t_lead                   w_sel;
    logic signed [N_W-1:0]   w_d21m12, w_d02m20, w_d10m01;
    logic signed [N_W-1:0]   w_s10p01, w_s20p02, w_s21p12;

    assign w_hold  = r_v & i_stall;
    assign o_stall = w_hold;

    // Pick the branch, the leading axis and the numerators
    always_comb begin
        w_d0     = SW'(i_m00);
        w_d1     = SW'(i_m11);
        w_d2     = SW'(i_m22);
        w_trace  = w_d0 + w_d1 + w_d2;
        w_d21m12 = N_W'(i_m21) - N_W'(i_m12);
        w_d02m20 = N_W'(i_m02) - N_W'(i_m20);
        w_d10m01 = N_W'(i_m10) - N_W'(i_m01);
        w_s10p01 = N_W'(i_m10) + N_W'(i_m01);
        w_s20p02 = N_W'(i_m20) + N_W'(i_m02);
        w_s21p12 = N_W'(i_m21) + N_W'(i_m12);

        // Largest diagonal entry; ties keep the lower axis
        w_sel  = LEAD_X;
        w_dmax = w_d0;
        if (w_d1 > w_d0) begin
            w_sel  = LEAD_Y;
            w_dmax = w_d1;
        end
        if (w_d2 > w_dmax) begin
            w_sel = LEAD_Z;
        end

        n_side.num_a = w_d21m12;
        n_side.num_b = w_d02m20;
        n_side.num_c = w_d10m01;
        n_side.lead  = LEAD_W;
        if (w_trace > 0) begin
            w_rad = w_trace + ONE;
        end else begin
            n_side.lead = w_sel;
            case (w_sel)
                LEAD_X: begin
                    w_rad        = w_d0 - (w_d1 + w_d2) + ONE;
                    n_side.num_a = w_d21m12;
                    n_side.num_b = w_s10p01;
                    n_side.num_c = w_s20p02;
                end
                LEAD_Y: begin
                    w_rad        = w_d1 - (w_d2 + w_d0) + ONE;
                    n_side.num_a = w_d02m20;
                    n_side.num_b = w_s10p01;
                    n_side.num_c = w_s21p12;
                end
                LEAD_Z: begin
                    w_rad        = w_d2 - (w_d0 + w_d1) + ONE;
                    n_side.num_a = w_d10m01;
                    n_side.num_b = w_s20p02;
                    n_side.num_c = w_s21p12;
                end
                default: begin
                    w_rad = '0;
                end
            endcase
        end

        // Clamp a negative radicand to zero
        if (w_rad < 0) begin
            n_rad = '0;
        end else begin
            n_rad = w_rad[RAD_W-1:0];
        end
    end

    // Hold while this stage is full and the next stage stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!w_hold) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold) begin
            r_rad  <= n_rad;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

// ===== rtl/core/rmq_sqrt.sv =====
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word carried alongside.
// ---------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int V_W  = 32,
    parameter int SB_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [V_W-1:0]           i_v,
    input  logic [SB_W-1:0]          i_side,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [(V_W+1)/2-1:0]     o_root,
    output logic [SB_W-1:0]          o_side
);
    localparam int SQ_W = (V_W + 1) / 2;
    localparam int VS_W = 2 * SQ_W;

    logic [SQ_W-1:0] r_v;
    logic [VS_W-1:0] r_rem  [SQ_W];
    logic [VS_W-1:0] r_res  [SQ_W];
    logic [SB_W-1:0] r_side [SQ_W];
    logic [SQ_W:0]   w_hold;

    // Stall chain: a stage holds when it is full and the next one holds
    always_comb begin
        w_hold[SQ_W] = i_stall;
        for (int k = SQ_W - 1; k >= 0; k--) begin
            w_hold[k] = r_v[k] & w_hold[k+1];
        end
    end

    assign o_stall = w_hold[0];

    for (genvar k = 0; k < SQ_W; k++) begin : g_step
        localparam logic [VS_W-1:0] BIT = VS_W'(1) << (2 * (SQ_W - 1 - k));

        logic            w_v_in;
        logic [VS_W-1:0] w_rem_in, w_res_in, n_rem, n_res;
        logic [SB_W-1:0] w_side_in;
        logic [VS_W:0]   w_try;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = VS_W'(i_v);
            assign w_res_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_res_in  = r_res[k-1];
            assign w_side_in = r_side[k-1];
        end

        // Try to subtract the trial square and settle one root bit
        always_comb begin
            w_try = {1'b0, w_res_in} + {1'b0, BIT};
            if ({1'b0, w_rem_in} >= w_try) begin
                n_rem = w_rem_in - w_try[VS_W-1:0];
                n_res = (w_res_in >> 1) + BIT;
            end else begin
                n_rem = w_rem_in;
                n_res = w_res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (!w_hold[k]) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_hold[k]) begin
                r_rem[k]  <= n_rem;
                r_res[k]  <= n_res;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[SQ_W-1];
    assign o_root  = r_res[SQ_W-1][SQ_W-1:0];
    assign o_side  = r_side[SQ_W-1];

endmodule

// ===== rtl/core/rmq_div.sv =====
// ---------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider: round(|n| * 2^FRAC_BITS / (2*s)),
// one quotient bit per stage, with a sideband word carried alongside.
// ---------------------------------------------------------------------------
module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int S_W       = 16,
    parameter int SB_W      = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [2:0][rmq_pkg::N_W-1:0]           i_num,
    input  logic [S_W-1:0]                         i_root,
    input  logic [SB_W-1:0]                        i_side,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [2:0][FRAC_BITS+17:0]             o_quot,
    output logic [2:0]                             o_neg,
    output logic [SB_W-1:0]                        o_side
);
    import rmq_pkg::*;

    localparam int NW  = FRAC_BITS + 18;
    localparam int D_W = S_W + 1;
    localparam int R_W = D_W + 1;

    logic [NW-1:0]             r_v;
    logic [2:0][NW-1:0]        r_acc  [NW];
    logic [2:0][R_W-1:0]       r_rem  [NW];
    logic [D_W-1:0]            r_den  [NW];
    logic [2:0]                r_neg  [NW];
    logic [SB_W-1:0]           r_side [NW];
    logic [NW:0]               w_hold;
    logic [2:0][NW-1:0]        w_dvd;
    logic [2:0]                w_neg;
    logic [N_W-1:0]            w_mag [3];

    // Stall chain
    always_comb begin
        w_hold[NW] = i_stall;
        for (int k = NW - 1; k >= 0; k--) begin
            w_hold[k] = r_v[k] & w_hold[k+1];
        end
    end

    assign o_stall = w_hold[0];

    // Form |n| << FRAC_BITS plus s, so that flooring by 2s rounds half away
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_neg[l] = i_num[l][N_W-1];
            w_mag[l] = w_neg[l] ? N_W'(-i_num[l]) : i_num[l];
            w_dvd[l] = (NW'(w_mag[l]) << FRAC_BITS) + NW'(i_root);
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic                 w_v_in;
        logic [2:0][NW-1:0]   w_acc_in, n_acc;
        logic [2:0][R_W-1:0]  w_rem_in, n_rem;
        logic [D_W-1:0]       w_den_in;
        logic [2:0]           w_neg_in;
        logic [SB_W-1:0]      w_side_in;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_acc_in  = w_dvd;
            assign w_rem_in  = '0;
            assign w_den_in  = {i_root, 1'b0};
            assign w_neg_in  = w_neg;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_acc_in  = r_acc[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_neg_in  = r_neg[k-1];
            assign w_side_in = r_side[k-1];
        end

        // Shift in one dividend bit and subtract the divisor if it fits
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_rem[l] = {w_rem_in[l][R_W-2:0], w_acc_in[l][NW-1]};
                n_acc[l] = {w_acc_in[l][NW-2:0], 1'b0};
                if (n_rem[l] >= R_W'(w_den_in)) begin
                    n_rem[l]    = n_rem[l] - R_W'(w_den_in);
                    n_acc[l][0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (!w_hold[k]) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_hold[k]) begin
                r_acc[k]  <= n_acc;
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den_in;
                r_neg[k]  <= w_neg_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_acc[NW-1];
    assign o_neg   = r_neg[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix to unit quaternion in signed fixed point, pipelined.
//
//   channel  direction  handshake           word
//   input    in         i_valid / o_stall   i_m00 .. i_m22
//   output   out        o_valid / i_stall   o_quat_w .. o_quat_z, o_zero_root
//
// One matrix enters per cycle while o_stall is low; the square root and
// divider behind the front stage settle one result bit per stage.
// Reset clears only the valid bits. A stall at the output holds only the
// stages that are full; empty stages behind it keep filling.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m00,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m01,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m02,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m10,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m11,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m12,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m20,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m21,
    input  logic signed [rmq_pkg::M_W-1:0]   i_m22,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [rmq_pkg::Q_W-1:0]   o_quat_w,
    output logic signed [rmq_pkg::Q_W-1:0]   o_quat_x,
    output logic signed [rmq_pkg::Q_W-1:0]   o_quat_y,
    output logic signed [rmq_pkg::Q_W-1:0]   o_quat_z,
    output logic                             o_zero_root
);
    import rmq_pkg::*;

    localparam int RAD_W  = rad_width(FRAC_BITS);
    localparam int V_W    = RAD_W + FRAC_BITS;
    localparam int S_W    = (V_W + 1) / 2;
    localparam int NW     = FRAC_BITS + 18;
    localparam int DSB_W  = 2 + 1 + (S_W - 1);
    localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

    // Front stage
    logic             f_valid, f_stall;
    logic [RAD_W-1:0] f_rad;
    t_side            f_side;

    // Square root
    logic             s_valid, s_stall;
    logic [S_W-1:0]   s_root;
    t_side            s_side;
    logic [$bits(t_side)-1:0] s_side_bits;

    // Divider
    logic              d_valid, d_stall;
    logic [2:0][NW-1:0] d_quot;
    logic [2:0]        d_neg;
    logic [DSB_W-1:0]  d_side;
    logic [DSB_W-1:0]  w_dside_in;
    logic [2:0][N_W-1:0] w_nums;

    // Output stage
    logic             r_ov;
    logic [Q_W-1:0]   r_qw, r_qx, r_qy, r_qz;
    logic             r_zr;
    logic [Q_W-1:0]   n_qw, n_qx, n_qy, n_qz;
    logic             w_out_hold;
    t_lead            w_lead;
    logic             w_zero;
    logic [S_W-2:0]   w_half;
    logic [Q_W-1:0]   w_lead_val;
    logic [Q_W-1:0]   w_q [3];

    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_valid (f_valid),
        .i_stall (f_stall),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    rmq_sqrt #(
        .V_W  (V_W),
        .SB_W ($bits(t_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_v     ({f_rad, {FRAC_BITS{1'b0}}}),
        .i_side  (f_side),
        .o_valid (s_valid),
        .i_stall (s_stall),
        .o_root  (s_root),
        .o_side  (s_side_bits)
    );

    assign s_side     = t_side'(s_side_bits);
    assign w_nums     = {s_side.num_c, s_side.num_b, s_side.num_a};
    assign w_dside_in = {s_side.lead, (s_root == '0), s_root[S_W-1:1]};

    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .S_W       (S_W),
        .SB_W      (DSB_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_stall (s_stall),
        .i_num   (w_nums),
        .i_root  (s_root),
        .i_side  (w_dside_in),
        .o_valid (d_valid),
        .i_stall (d_stall),
        .o_quot  (d_quot),
        .o_neg   (d_neg),
        .o_side  (d_side)
    );

    assign w_out_hold = r_ov & i_stall;
    assign d_stall    = w_out_hold;

    // Saturate the quotients and the halved root, then route them
    always_comb begin
        w_lead = t_lead'(d_side[DSB_W-1 -: 2]);
        w_zero = d_side[S_W-1];
        w_half = d_side[S_W-2:0];

        if (S_W - 1 > Q_W - 1 && (w_half >> (Q_W - 1)) != '0) begin
            w_lead_val = POS_MAX;
        end else begin
            w_lead_val = Q_W'(w_half);
        end

        for (int l = 0; l < 3; l++) begin
            if (d_neg[l]) begin
                if (d_quot[l] > NW'(NEG_MAX)) begin
                    w_q[l] = NEG_MAX;
                end else begin
                    w_q[l] = Q_W'(-d_quot[l]);
                end
            end else begin
                if (d_quot[l] > NW'(POS_MAX)) begin
                    w_q[l] = POS_MAX;
                end else begin
                    w_q[l] = d_quot[l][Q_W-1:0];
                end
            end
        end

        case (w_lead)
            LEAD_W: begin
                n_qw = w_lead_val; n_qx = w_q[0]; n_qy = w_q[1]; n_qz = w_q[2];
            end
            LEAD_X: begin
                n_qw = w_q[0]; n_qx = w_lead_val; n_qy = w_q[1]; n_qz = w_q[2];
            end
            LEAD_Y: begin
                n_qw = w_q[0]; n_qx = w_q[1]; n_qy = w_lead_val; n_qz = w_q[2];
            end
            LEAD_Z: begin
                n_qw = w_q[0]; n_qx = w_q[1]; n_qy = w_q[2]; n_qz = w_lead_val;
            end
            default: begin
                n_qw = '0; n_qx = '0; n_qy = '0; n_qz = '0;
            end
        endcase

        // Zero root clears every component
        if (w_zero) begin
            n_qw = '0;
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
        end
    end

    // Output register holds the word while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!w_out_hold) begin
            r_ov <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_out_hold) begin
            r_qw <= n_qw;
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
            r_zr <= w_zero;
        end
    end

    assign o_valid     = r_ov;
    assign o_quat_w    = r_qw;
    assign o_quat_x    = r_qx;
    assign o_quat_y    = r_qy;
    assign o_quat_z    = r_qz;
    assign o_zero_root = r_zr;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Streams matrices through the rotation matrix to quaternion pipeline and
// compares each output word against a bit-exact fixed-point predictor.
// A directed table covers identity, axis flips and extremes;
// random rotations and raw noise follow, with random gaps on both sides
// and one long output hold-off to fill the pipeline.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int FB        = rmq_pkg::FRAC_BITS_DEF;
    localparam int ONE       = 1 << FB;
    localparam int N_RANDOM  = 1200;
    localparam int WDOG_MAX  = 4000;
    localparam int LATENCY   = 50;

    typedef struct {
        logic signed [15:0] m [9];
    } t_mat;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic               zr;
    } t_quat;

    typedef struct {
        t_mat  mat;
        bit    has_exp;
        t_quat exp_q;
    } t_row;

    logic i_clk, i_rst_n, i_valid, i_stall;
    logic o_stall, o_valid, o_zero_root;
    logic signed [15:0] i_m [9];
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;

    t_quat quat_queue[$];
    t_mat  send_queue[$];
    int    n_mismatch;
    int    idle_cycles;
    bit    send_done;
    bit    hold_off;

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(i_m[0]), .i_m01(i_m[1]), .i_m02(i_m[2]),
        .i_m10(i_m[3]), .i_m11(i_m[4]), .i_m12(i_m[5]),
        .i_m20(i_m[6]), .i_m21(i_m[7]), .i_m22(i_m[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z), .o_zero_root(o_zero_root)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Integer square root, floor
    function automatic longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // n / (2 s) in Q(FB), rounded half away from zero
    function automatic longint half_recip_mul(longint n, longint s);
        longint mag, d, q;
        mag = (n < 0 ? -n : n) << FB;
        d = 2 * s;
        q = (2 * mag + d) / (2 * d);
        return n < 0 ? -q : q;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_quat predict_quat(t_mat a);
        longint m [3][3];
        longint q [3];
        longint w, tr, s, rad;
        int i, j, k;
        t_quat r;
        for (int n = 0; n < 9; n++) m[n / 3][n % 3] = a.m[n];
        r.zr = 0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            s = root_floor((tr + ONE) << FB);
            w = s >>> 1;
            q[0] = half_recip_mul(m[2][1] - m[1][2], s);
            q[1] = half_recip_mul(m[0][2] - m[2][0], s);
            q[2] = half_recip_mul(m[1][0] - m[0][1], s);
        end else begin
            i = 0;
            if (m[1][1] > m[i][i]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = (m[i][i] - (m[j][j] + m[k][k])) + ONE;
            if (rad < 0) rad = 0;
            s = root_floor(rad << FB);
            if (s == 0) begin
                r.zr = 1;
                w = 0;
                q[0] = 0; q[1] = 0; q[2] = 0;
            end else begin
                q[i] = s >>> 1;
                w = half_recip_mul(m[k][j] - m[j][k], s);
                q[j] = half_recip_mul(m[j][i] + m[i][j], s);
                q[k] = half_recip_mul(m[k][i] + m[i][k], s);
            end
        end
        r.w = clip16(w); r.x = clip16(q[0]); r.y = clip16(q[1]); r.z = clip16(q[2]);
        return r;
    endfunction

    function automatic t_mat mk_mat(int a0, a1, a2, a3, a4, a5, a6, a7, a8);
        t_mat t;
        t.m = '{a0[15:0], a1[15:0], a2[15:0], a3[15:0], a4[15:0],
                a5[15:0], a6[15:0], a7[15:0], a8[15:0]};
        return t;
    endfunction

    function automatic t_quat mk_quat(int w, x, y, z, bit zr);
        t_quat q;
        q.w = w[15:0]; q.x = x[15:0]; q.y = y[15:0]; q.z = z[15:0]; q.zr = zr;
        return q;
    endfunction

    // Random rotation from a unit-ish quaternion with random content
    function automatic t_mat rand_rotation();
        real a, b, c, d, n;
        t_mat t;
        real r [9];
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        d = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1e-9;
        a /= n; b /= n; c /= n; d /= n;
        r = '{1 - 2 * (c * c + d * d), 2 * (b * c - a * d), 2 * (b * d + a * c),
              2 * (b * c + a * d), 1 - 2 * (b * b + d * d), 2 * (c * d - a * b),
              2 * (b * d - a * c), 2 * (c * d + a * b), 1 - 2 * (b * b + c * c)};
        for (int n2 = 0; n2 < 9; n2++) begin
            longint v;
            v = longint'(r[n2] * ONE) + $urandom_range(0, 4) - 2;
            t.m[n2] = clip16(v);
        end
        return t;
    endfunction

    // Sender: drive each word after a random gap
    initial begin
        t_row rows [$];
        t_mat mt;
        int gap;
        i_rst_n = 0;
        i_valid = 0;
        for (int n = 0; n < 9; n++) i_m[n] = '0;
        send_done = 0;
        n_mismatch = 0;
        // identity, axis flips, extremes
        rows.push_back('{mk_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
                         mk_quat(ONE, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1,
                         mk_quat(0, ONE, 0, 0, 0)});
        rows.push_back('{mk_mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 1,
                         mk_quat(0, 0, ONE, 0, 0)});
        rows.push_back('{mk_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE), 1,
                         mk_quat(0, 0, 0, ONE, 0)});
        rows.push_back('{mk_mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767), 0,
                         mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 0,
                         mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767), 0, mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768), 0, mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(-1, 32767, -32768, -32768, 0, 32767,
                                32767, -32768, 1), 0, mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(0, 0, 0, 0, 0, 0, 0, 0, 1), 0, mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE), 0,
                         mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(-ONE, 5, 7, 9, -ONE, 3, 2, 8, -ONE), 0,
                         mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(100, 32767, -32768, 32767, 100, 32767,
                                -32768, -32768, 100), 0, mk_quat(0, 0, 0, 0, 0)});
        rows.push_back('{mk_mat(32767, -32768, 32767, -32768, 32767, -32768,
                                32767, -32768, -32768), 0, mk_quat(0, 0, 0, 0, 0)});
        foreach (rows[r]) begin
            if (rows[r].has_exp) quat_queue.push_back(rows[r].exp_q);
            else quat_queue.push_back(predict_quat(rows[r].mat));
            send_queue.push_back(rows[r].mat);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) < 7) mt = rand_rotation();
            else for (int e = 0; e < 9; e++) mt.m[e] = 16'($urandom);
            quat_queue.push_back(predict_quat(mt));
            send_queue.push_back(mt);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        foreach (send_queue[n]) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (n >= 300 && n < 500) gap = 0;
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1;
            for (int e = 0; e < 9; e++) i_m[e] <= send_queue[n].m[e];
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 0;
        send_done = 1;
    end

    // Receiver: random stall per word, one long hold-off mid run
    initial begin
        int gap, n_seen;
        i_stall = 1;
        hold_off = 0;
        n_seen = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (n_seen >= 250 && n_seen < 400) gap = 0;
            if (n_seen == 300 && !hold_off) begin
                hold_off = 1;
                gap = 400;
            end
            if (gap > 0) begin
                i_stall <= 1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            n_seen++;
        end
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        t_quat q;
        if (i_rst_n && o_valid && !i_stall) begin
            if (quat_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected output word");
            end else begin
                q = quat_queue.pop_front();
                if (o_quat_w !== q.w || o_quat_x !== q.x || o_quat_y !== q.y ||
                    o_quat_z !== q.z || o_zero_root !== q.zr) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("exp w=%0d x=%0d y=%0d z=%0d zr=%0b  got %0d %0d %0d %0d %0b",
                                 q.w, q.x, q.y, q.z, q.zr, o_quat_w, o_quat_x,
                                 o_quat_y, o_quat_z, o_zero_root);
                end
            end
        end
    end

    // Watchdog and end of run
    initial begin
        idle_cycles = 0;
        @(posedge i_clk iff i_rst_n);
        while (!(send_done && quat_queue.size() == 0) && idle_cycles < WDOG_MAX) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("Mismatches found");
        end else begin
            repeat (2 * LATENCY) @(posedge i_clk);
            if (n_mismatch == 0) $display("No mismatches found");
            else $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== rotation_matrix_to_quaternion.f =====
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
tb/tb_top.sv
